// ----- rtl/core/rmmba_pkg.sv -----
// ----------------------------------------------------------------------------
// rmmba_pkg
// Shared widths, types and constants for the running min/max block averager.
// ----------------------------------------------------------------------------
package rmmba_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 20;
	localparam int CNT_W    = 5;
	localparam int AVG_W    = 24;
	localparam int FRAC_W   = 8;
	localparam int DVD_W    = SUM_W + FRAC_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic        [CNT_W-1:0]    cnt_t;
	typedef logic signed [AVG_W-1:0]    avg_t;
	typedef logic        [DVD_W-1:0]    dvd_t;

	// register map (word index)
	localparam logic REG_BLOCK_LENGTH = 1'b0;

	localparam cnt_t    LEN_RESET = 5'd5;
	localparam cnt_t    LEN_MAX   = 5'd16;
	localparam cnt_t    LEN_MIN   = 5'd1;
	localparam sample_t MAX_RESET = -16'sd1;
	localparam sample_t MIN_RESET = 16'sd32767;

endpackage

// ----- rtl/core/running_min_max_block_average.sv -----
// Sequence: a request is registered, then the channel is updated and the result
//   registered; when a block completes, the update is followed by 28 divide steps
//   and a sign fix before the result is registered.
// Throughput: one request at a time; the next request is taken in the cycle after the
//   result is taken, so the bit-serial restoring divider sets the rate at block ends.
// Reset: arst_n clears the channel pointer, sums and counts, sets every max to
//   -1 and every min to 32767, and block_length to 5.
// ----------------------------------------------------------------------------
// running_min_max_block_average
// Round-robin per-channel running max/min with a block average in Q.8, the
// average computed by a shared one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module running_min_max_block_average
	import rmmba_pkg::*;
#(
	parameter int NUM_CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic signed [15:0]    sample,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  channel,
	output logic signed [15:0]    max_value,
	output logic signed [15:0]    min_value,
	output logic                  average_valid,
	output logic signed [23:0]    average,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_NEG  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [PTR_W-1:0] ptr_q;
	cnt_t             blk_len_q;
	sample_t          sample_q;

	sample_t max_q   [NUM_CHANNELS];
	sample_t min_q   [NUM_CHANNELS];
	sum_t    sum_q   [NUM_CHANNELS];
	cnt_t    count_q [NUM_CHANNELS];

	// divider state
	dvd_t              dvd_q;
	cnt_t              rem_q;
	cnt_t              divisor_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              neg_q;

	// result register
	logic    result_valid_q;
	logic    channel_q;
	sample_t max_out_q;
	sample_t min_out_q;
	logic    avg_valid_q;
	avg_t    avg_q;

	logic             sample_take;
	logic             cfg_write;
	logic [PTR_W-1:0] ptr_next;
	cnt_t             eff_len;
	sample_t          max_new;
	sample_t          min_new;
	sum_t             sum_new;
	cnt_t             n_new;
	logic             blk_done;
	logic [SUM_W-1:0] sum_mag;
	logic [CNT_W:0]   rem_sh;
	logic             rem_ge;
	logic [CNT_W:0]   rem_sub;
	avg_t             quot;

	assign sample_take  = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign cfg_write    = psel && penable && pwrite && pready;
	assign pready       = 1'b1;

	// read back the length register; other words read zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BLOCK_LENGTH) begin
			prdata[CNT_W-1:0] = blk_len_q;
		end
	end

	// advance the round-robin pointer with wrap
	assign ptr_next = (ptr_q == PTR_W'(NUM_CHANNELS - 1)) ? '0 : ptr_q + 1'b1;

	// clamp the configured length into 1..16
	always_comb begin
		if (blk_len_q == '0) begin
			eff_len = LEN_MIN;
		end else if (blk_len_q > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = blk_len_q;
		end
	end

	// per-channel update terms for the selected channel
	assign max_new  = (sample_q > max_q[ptr_q]) ? sample_q : max_q[ptr_q];
	assign min_new  = (sample_q < min_q[ptr_q]) ? sample_q : min_q[ptr_q];
	assign sum_new  = sum_q[ptr_q] + SUM_W'(sample_q);
	assign n_new    = count_q[ptr_q] + 1'b1;
	assign blk_done = (n_new >= eff_len);
	assign sum_mag  = sum_new[SUM_W-1] ? (SUM_W)'(-sum_new) : sum_new;

	// one restoring divide step
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, divisor_q});
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign quot    = dvd_q[AVG_W-1:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= LEN_RESET;
		end else if (cfg_write && (paddr[2] == REG_BLOCK_LENGTH)) begin
			blk_len_q <= pwdata[CNT_W-1:0];
		end
	end

	// sequencer, channel state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ptr_q          <= '0;
			sample_q       <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			divisor_q      <= '0;
			dcnt_q         <= '0;
			neg_q          <= 1'b0;
			result_valid_q <= 1'b0;
			channel_q      <= 1'b0;
			max_out_q      <= '0;
			min_out_q      <= '0;
			avg_valid_q    <= 1'b0;
			avg_q          <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				max_q[c]   <= MAX_RESET;
				min_q[c]   <= MIN_RESET;
				sum_q[c]   <= '0;
				count_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_take) begin
						sample_q <= sample;
						ptr_q    <= ptr_next;
						state_q  <= ST_UPD;
					end
				end
				ST_UPD: begin
					max_q[ptr_q] <= max_new;
					min_q[ptr_q] <= min_new;
					channel_q    <= ptr_q[0];
					max_out_q    <= max_new;
					min_out_q    <= min_new;
					avg_valid_q  <= blk_done;
					if (blk_done) begin
						sum_q[ptr_q]   <= '0;
						count_q[ptr_q] <= '0;
						dvd_q          <= {sum_mag, {FRAC_W{1'b0}}};
						rem_q          <= '0;
						divisor_q      <= n_new;
						neg_q          <= sum_new[SUM_W-1];
						dcnt_q         <= '0;
						state_q        <= ST_DIV;
					end else begin
						sum_q[ptr_q]   <= sum_new;
						count_q[ptr_q] <= n_new;
						avg_q          <= '0;
						result_valid_q <= 1'b1;
						state_q        <= ST_OUT;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
					dvd_q  <= {dvd_q[DVD_W-2:0], rem_ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					// restore the sign; magnitude divide gives truncation toward zero
					avg_q          <= neg_q ? -quot : quot;
					result_valid_q <= 1'b1;
					state_q        <= ST_OUT;
				end
				ST_OUT: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign channel       = channel_q;
	assign max_value     = max_out_q;
	assign min_value     = min_out_q;
	assign average_valid = avg_valid_q;
	assign average       = avg_q;

	// a pending result blocks new requests
	a_result_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> sample_stall)
		else $error("request accepted while a result is pending");

	// average reads zero unless a block completed
	a_average_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !average_valid) |-> (average == '0))
		else $error("average not zero without a completed block");

	// block count always stays below the largest length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[ptr_q] < LEN_MAX)
		else $error("block count out of range");

	// divider always finishes into the sign fix step
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && dcnt_q == DCNT_W'(DVD_W - 1)) |=> (state_q == ST_NEG))
		else $error("divider did not finish");

	// divisor is a valid block length while dividing
	a_divisor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (divisor_q != '0 && divisor_q <= LEN_MAX))
		else $error("divisor out of range");

endmodule

// ----- bench/running_min_max_block_average_tb.sv -----
// ----------------------------------------------------------------------------
// running_min_max_block_average_tb
// Self-checking bench for the round-robin running max/min block averager.
// Samples go in on a valid/stall channel. A scoreboard predicts each result:
// channel, running max and min, and the Q.8 block average on block ends.
// Every accepted result is compared field by field with the oldest prediction.
// The block length register is rewritten between phases over the APB port,
// covering zero and over-range values and a length lowered mid-block.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module running_min_max_block_average_tb;
	import rmmba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 2;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_SEGMENTS = 8;
	localparam int SEGMENT_ITEMS = 250;
	localparam logic [2:0] LEN_ADDR = {REG_BLOCK_LENGTH, 2'b00};
	localparam logic [2:0] SPARE_ADDR_LO = 3'd4;
	localparam logic [2:0] SPARE_ADDR_HI = 3'd7;
	localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);
	localparam sample_t SAMPLE_MAX = sample_t'(16'h7FFF);

	typedef struct {
		logic    channel;
		sample_t max_value;
		sample_t min_value;
		logic    average_valid;
		avg_t    average;
	} channel_stats_t;

	// Per-channel statistics predictor and result checker
	class channel_stats_board;
		int errors;
		int results_seen;
		int averages_seen;
		cnt_t length_reg;
		int ptr;
		sample_t ch_max[NCH];
		sample_t ch_min[NCH];
		int ch_sum[NCH];
		int ch_cnt[NCH];
		channel_stats_t expected_results[$];

		function new();
			errors = 0;
			results_seen = 0;
			averages_seen = 0;
			length_reg = LEN_RESET;
			ptr = 0;
			for (int c = 0; c < NCH; c++) begin
				ch_max[c] = MAX_RESET;
				ch_min[c] = MIN_RESET;
				ch_sum[c] = 0;
				ch_cnt[c] = 0;
			end
		endfunction

		function void set_length(cnt_t v);
			length_reg = v;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Advance the pointer, update the channel and queue the expected result
		function void note_sample(sample_t s);
			channel_stats_t e;
			int n;
			int eff;
			longint q;
			ptr = (ptr + 1 >= NCH) ? 0 : ptr + 1;
			if (s > ch_max[ptr]) ch_max[ptr] = s;
			if (s < ch_min[ptr]) ch_min[ptr] = s;
			ch_sum[ptr] += s;
			n = ch_cnt[ptr] + 1;
			eff = (length_reg < LEN_MIN) ? LEN_MIN : (length_reg > LEN_MAX) ? LEN_MAX : length_reg;
			e.channel = ptr[0];
			e.max_value = ch_max[ptr];
			e.min_value = ch_min[ptr];
			e.average_valid = (n >= eff);
			e.average = '0;
			if (n >= eff) begin
				q = (longint'(ch_sum[ptr]) * 256) / n;
				e.average = avg_t'(q);
				ch_sum[ptr] = 0;
				ch_cnt[ptr] = 0;
			end else begin
				ch_cnt[ptr] = n;
			end
			expected_results.push_back(e);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(channel_stats_t got);
			channel_stats_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: channel %0d", got.channel);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (want.average_valid) averages_seen++;
			if (got.channel !== want.channel) begin
				$error("channel: expected %0d, got %0d", want.channel, got.channel);
				errors++;
			end
			if (got.max_value !== want.max_value) begin
				$error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
				errors++;
			end
			if (got.min_value !== want.min_value) begin
				$error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
				errors++;
			end
			if (got.average_valid !== want.average_valid) begin
				$error("average_valid: expected %0d, got %0d",
					want.average_valid, got.average_valid);
				errors++;
			end
			if (got.average !== want.average) begin
				$error("average: expected %0d, got %0d", want.average, got.average);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	logic channel;
	sample_t max_value;
	sample_t min_value;
	logic average_valid;
	avg_t average;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	channel_stats_board board;
	int send_idle_pct;
	int recv_idle_pct;
	int samples_sent;
	int length_writes;

	running_min_max_block_average #(.NUM_CHANNELS(NCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.channel(channel),
		.max_value(max_value),
		.min_value(min_value),
		.average_valid(average_valid),
		.average(average),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Take results and stall the result channel at random
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			board.check_result('{channel, max_value, min_value, average_valid, average});
		end
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Offer one sample request, idling first at random, and hold it until taken
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		board.note_sample(s);
		samples_sent++;
	endtask

	// Hold off the sender until every expected result is back, then settle
	task automatic wait_drain();
		sample_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == LEN_ADDR) begin
			board.set_length(data[CNT_W-1:0]);
			length_writes++;
		end
		@(posedge clk);
	endtask

	// Read the block length back and compare with the value last written
	task automatic check_length_reg();
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LEN_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== 32'(board.length_reg)) begin
			$error("block_length: expected %0d, got %0d", board.length_reg, got);
			board.errors++;
		end
		@(posedge clk);
	endtask

	// Write a length with random junk above the register's bits
	task automatic set_block_length(input cnt_t len);
		wait_drain();
		reg_write(LEN_ADDR, ($urandom() & ~32'h1F) | 32'(len));
		check_length_reg();
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(7))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return sample_t'($urandom_range(16) - 8);
			3: return sample_t'($urandom_range(SAMPLE_W - 1) << 1);
			default: return sample_t'($urandom());
		endcase
	endfunction

	initial begin
		cnt_t seg_len;
		board = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 34;
		recv_idle_pct = 85;
		samples_sent = 0;
		length_writes = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: max at minus one and min at the largest sample
		check_length_reg();
		send_sample(-16'sd1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(-16'sd2);

		// Length lowered mid-block: both channels hold three samples already
		set_block_length(5'd2);
		send_sample(16'sd3);
		send_sample(-16'sd5);

		// Length one at the sample extremes, then length zero acting as one
		set_block_length(5'd1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		set_block_length(5'd0);
		send_sample(16'sd100);
		send_sample(-16'sd100);

		// Writes to unknown registers are dropped
		wait_drain();
		reg_write(SPARE_ADDR_LO, 32'd3);
		reg_write(SPARE_ADDR_HI, 32'hFFFF_FFE1);
		check_length_reg();

		// Negative means truncate toward zero
		set_block_length(5'd3);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd0);
		send_sample(-16'sd2);

		// Random segments, each at its own block length and idle mix
		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			send_idle_pct = (seg < 3) ? 34 : (seg < 6) ? 85 : 0;
			recv_idle_pct = (seg < 3) ? 85 : (seg < 6) ? 34 : 0;
			case (seg)
				0: seg_len = LEN_MAX;
				1: seg_len = LEN_MIN;
				2: seg_len = 5'd31;
				3: seg_len = 5'd0;
				4: seg_len = 5'd17;
				default: seg_len = cnt_t'($urandom_range(31));
			endcase
			set_block_length(seg_len);
			for (int k = 0; k < SEGMENT_ITEMS; k++) begin
				if (k == SEGMENT_ITEMS / 2) wait_drain();
				send_sample(random_sample());
			end
		end

		wait_drain();
		$display("Covered %0d samples over %0d block length settings with random idling",
			samples_sent, length_writes);
		$display("Checked %0d results, %0d of them block averages",
			board.results_seen, board.averages_seen);
		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/rmmba_pkg.sv
rtl/core/running_min_max_block_average.sv
bench/running_min_max_block_average_tb.sv
